### src/esde_pkg.sv
// Package for the event-stream data extractor.
// Byte constants and the result type shared by the parser and the top level.
// No dependencies.
package esde_pkg;

	localparam int unsigned ByteW = 8;

	localparam logic [ByteW-1:0] BYTE_NL    = 8'd10;
	localparam logic [ByteW-1:0] BYTE_D     = 8'h64;
	localparam logic [ByteW-1:0] BYTE_A     = 8'h61;
	localparam logic [ByteW-1:0] BYTE_T     = 8'h74;
	localparam logic [ByteW-1:0] BYTE_COLON = 8'h3a;
	localparam logic [ByteW-1:0] BYTE_SPACE = 8'h20;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] payload_byte;
		logic             frame_end;
	} result_t;

endpackage

### src/esde_parse.sv
// Line parser of the event-stream data extractor: holds the line state and
// works out the result of one byte in the same cycle.
// Depends on esde_pkg.
module esde_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [esde_pkg::ByteW-1:0]    stream_byte,
	output esde_pkg::result_t             res
);

	typedef enum logic [2:0] {
		PH_START,
		PH_D,
		PH_DA,
		PH_DAT,
		PH_DATA,
		PH_COLON,
		PH_PAYLOAD,
		PH_IGNORE
	} phase_t;

	phase_t phase_q, phase_d;
	logic   after_nl_q, after_nl_d;
	logic   nonempty_q, nonempty_d;

	always_comb begin
		phase_d          = phase_q;
		after_nl_d       = after_nl_q;
		nonempty_d       = nonempty_q;
		res.valid        = 1'b0;
		res.payload_byte = stream_byte;
		res.frame_end    = 1'b0;
		if (stream_byte == esde_pkg::BYTE_NL) begin
			phase_d = PH_START;
			if (after_nl_q) begin
				// second newline of a pair closes the frame
				res.valid        = nonempty_q;
				res.frame_end    = 1'b1;
				res.payload_byte = '0;
				nonempty_d       = 1'b0;
				after_nl_d       = 1'b0;
			end else begin
				after_nl_d = 1'b1;
			end
		end else begin
			after_nl_d = 1'b0;
			unique case (phase_q)
				PH_START:
					phase_d = (stream_byte == esde_pkg::BYTE_D) ? PH_D : PH_IGNORE;
				PH_D:
					phase_d = (stream_byte == esde_pkg::BYTE_A) ? PH_DA : PH_IGNORE;
				PH_DA:
					phase_d = (stream_byte == esde_pkg::BYTE_T) ? PH_DAT : PH_IGNORE;
				PH_DAT:
					phase_d = (stream_byte == esde_pkg::BYTE_A) ? PH_DATA : PH_IGNORE;
				PH_DATA: begin
					if (stream_byte == esde_pkg::BYTE_COLON) begin
						// join a further data line with a newline
						phase_d          = PH_COLON;
						res.valid        = nonempty_q;
						res.payload_byte = esde_pkg::BYTE_NL;
					end else begin
						phase_d = PH_IGNORE;
					end
				end
				PH_COLON: begin
					// drop one leading space
					phase_d = PH_PAYLOAD;
					if (stream_byte != esde_pkg::BYTE_SPACE) begin
						res.valid  = 1'b1;
						nonempty_d = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					res.valid  = 1'b1;
					nonempty_d = 1'b1;
				end
				PH_IGNORE:
					phase_d = PH_IGNORE;
			endcase
		end
		if (!accept) begin
			phase_d    = phase_q;
			after_nl_d = after_nl_q;
			nonempty_d = nonempty_q;
			res.valid  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			after_nl_q <= 1'b0;
			nonempty_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			after_nl_q <= after_nl_d;
			nonempty_q <= nonempty_d;
		end
	end

endmodule

### src/event_stream_data_extractor.sv
// Top level of the event-stream data extractor: parser plus output register
// and skid stage. Depends on esde_pkg and esde_parse.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | stream_byte
//   output  | out_valid / out_ready| payload_byte, frame_end
//
// One byte per clock while in_ready is high; each result is registered in the
// output stage. The line state is updated in the accepting cycle, so bytes
// may follow back to back. A stalled output parks one result in the skid
// stage; in_ready drops only while that stage is full. Reset clears all line
// state and the valid flags of both stages; in_ready is high out of reset.
module event_stream_data_extractor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [esde_pkg::ByteW-1:0] stream_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [esde_pkg::ByteW-1:0] payload_byte,
	output logic                       frame_end
);

	esde_pkg::result_t res;
	esde_pkg::result_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              accept;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	esde_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.stream_byte (stream_byte),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || res.valid;
			skid_valid_q <= 1'b0;
		end else if (res.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload: move skid or fresh result forward, park a result when stalled
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res.valid) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign payload_byte = out_q.payload_byte;
	assign frame_end    = out_q.frame_end;

endmodule

### src/esde_check.sv
// Port checker for the event-stream data extractor, bound to the top level.
// Depends on esde_pkg.
module esde_check (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [esde_pkg::ByteW-1:0] stream_byte,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [esde_pkg::ByteW-1:0] payload_byte,
	input logic                       frame_end
);

	logic last_end_q;

	// remember whether the last delivered item closed a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_end_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_end_q <= frame_end;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(stream_byte))
		else $error("input item changed while stalled");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(frame_end))
		else $error("output item changed while stalled");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> payload_byte == '0)
		else $error("frame end carries a nonzero byte");

	a_skid_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output");

	a_no_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> !last_end_q)
		else $error("frame end without payload");

endmodule

bind event_stream_data_extractor esde_check u_esde_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.stream_byte  (stream_byte),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.payload_byte (payload_byte),
	.frame_end    (frame_end)
);

### tb/tb_event_stream_data_extractor.sv
`timescale 1ns / 100ps
// Self-checking testbench for event_stream_data_extractor: random event-stream text in,
// payload bytes and frame ends checked against a line-state predictor.
// Depends on esde_pkg and the extractor RTL.
module tb_event_stream_data_extractor;

	localparam int unsigned ByteW = esde_pkg::ByteW;

	typedef enum logic [2:0] {
		LP_START, LP_D, LP_DA, LP_DAT, LP_DATA, LP_COLON, LP_PAYLOAD, LP_IGNORE
	} line_pos_t;

	typedef struct packed {
		logic [ByteW-1:0] payload_byte;
		logic             frame_end;
	} frame_out_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [ByteW-1:0] stream_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [ByteW-1:0] payload_byte;
	logic             frame_end;

	logic [ByteW-1:0] stream_q[$];
	frame_out_t       expected_out_q[$];

	line_pos_t line_pos = LP_START;
	logic      nl_seen = 1'b0;
	logic      have_payload = 1'b0;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int err_cnt = 0;
	int results_seen = 0;
	int hold_left = 0;
	logic held_once = 1'b0;

	event_stream_data_extractor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_byte(payload_byte),
		.frame_end(frame_end)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Advance the line state by one byte and queue the result it causes, if any.
	function automatic void extract_step(input logic [ByteW-1:0] b);
		if (b == esde_pkg::BYTE_NL) begin
			if (nl_seen) begin
				if (have_payload)
					expected_out_q.push_back('{payload_byte: '0, frame_end: 1'b1});
				have_payload = 1'b0;
				nl_seen = 1'b0;
			end else begin
				nl_seen = 1'b1;
			end
			line_pos = LP_START;
			return;
		end
		nl_seen = 1'b0;
		case (line_pos)
			LP_START: line_pos = (b == esde_pkg::BYTE_D) ? LP_D : LP_IGNORE;
			LP_D:     line_pos = (b == esde_pkg::BYTE_A) ? LP_DA : LP_IGNORE;
			LP_DA:    line_pos = (b == esde_pkg::BYTE_T) ? LP_DAT : LP_IGNORE;
			LP_DAT:   line_pos = (b == esde_pkg::BYTE_A) ? LP_DATA : LP_IGNORE;
			LP_DATA: begin
				if (b == esde_pkg::BYTE_COLON) begin
					line_pos = LP_COLON;
					// join onto a non-empty payload
					if (have_payload)
						expected_out_q.push_back('{payload_byte: esde_pkg::BYTE_NL,
							frame_end: 1'b0});
				end else begin
					line_pos = LP_IGNORE;
				end
			end
			LP_COLON: begin
				line_pos = LP_PAYLOAD;
				if (b != esde_pkg::BYTE_SPACE) begin
					have_payload = 1'b1;
					expected_out_q.push_back('{payload_byte: b, frame_end: 1'b0});
				end
			end
			LP_PAYLOAD: begin
				have_payload = 1'b1;
				expected_out_q.push_back('{payload_byte: b, frame_end: 1'b0});
			end
			default: line_pos = LP_IGNORE;
		endcase
	endfunction

	// Any byte but newline, mostly printable text.
	function automatic logic [ByteW-1:0] text_byte();
		logic [ByteW-1:0] b;
		if ($urandom_range(99) < 70)
			return ByteW'($urandom_range(126, 32));
		b = ByteW'($urandom_range(254));
		if (b >= esde_pkg::BYTE_NL)
			b = b + 1'b1;
		return b;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stream_q.push_back(s[i]);
	endtask

	task automatic gen_line();
		int kind;
		int k;
		string pfx;
		logic [ByteW-1:0] b;
		pfx = "data:";
		kind = $urandom_range(99);
		if (kind < 50) begin
			push_text("data:");
			if ($urandom_range(1))
				stream_q.push_back(esde_pkg::BYTE_SPACE);
			repeat ($urandom_range(6)) stream_q.push_back(text_byte());
		end else if (kind < 65) begin
			// break off the prefix at a random position
			k = $urandom_range(4);
			for (int i = 0; i < k; i++)
				stream_q.push_back(pfx[i]);
			do
				b = text_byte();
			while (b == pfx[k]);
			stream_q.push_back(b);
			repeat ($urandom_range(4)) stream_q.push_back(text_byte());
		end else if (kind < 75) begin
			stream_q.push_back(esde_pkg::BYTE_COLON);
			repeat ($urandom_range(5)) stream_q.push_back(text_byte());
		end else if (kind < 85) begin
			repeat ($urandom_range(6, 1)) stream_q.push_back(text_byte());
		end else if (kind < 92) begin
			push_text("data: ");
			repeat ($urandom_range(4)) stream_q.push_back(text_byte());
			stream_q.push_back(8'h0d);
		end
		stream_q.push_back(esde_pkg::BYTE_NL);
	endtask

	task automatic gen_frames(input int n_bytes);
		int start;
		start = stream_q.size();
		while (stream_q.size() - start < n_bytes) begin
			repeat ($urandom_range(4, 1)) gen_line();
			stream_q.push_back(esde_pkg::BYTE_NL);
			if ($urandom_range(9) == 0)
				stream_q.push_back(esde_pkg::BYTE_NL);
		end
	endtask

	// Sender: hold the item until accepted, then offer the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			stream_byte <= '0;
		end else begin
			if (in_valid && in_ready)
				extract_step(stream_byte);
			if (!in_valid || in_ready) begin
				if (stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_valid <= 1'b1;
					stream_byte <= stream_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted result, drive ready with one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_out_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result payload_byte=%h frame_end=%b",
						$time, payload_byte, frame_end);
				end else if (expected_out_q[0].payload_byte !== payload_byte ||
						expected_out_q[0].frame_end !== frame_end) begin
					err_cnt++;
					$display("%0t: mismatch expected payload_byte=%h frame_end=%b, got %h %b",
						$time, expected_out_q[0].payload_byte, expected_out_q[0].frame_end,
						payload_byte, frame_end);
					void'(expected_out_q.pop_front());
				end else begin
					void'(expected_out_q.pop_front());
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held_once && results_seen >= 40) begin
				held_once = 1'b1;
				hold_left = 300;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < 3; p++) begin
			@(negedge clk);
			tx_idle_pct = (p == 0) ? 37 : (p == 1) ? 75 : 0;
			rx_idle_pct = (p == 0) ? 75 : (p == 1) ? 37 : 0;
			if (p == 0) begin
				// space drop, extreme bytes, empty data line joining, comment, triple newline
				push_text("data: A");
				stream_q.push_back(8'hff);
				stream_q.push_back(8'h00);
				stream_q.push_back(esde_pkg::BYTE_NL);
				push_text("data:\n\n");
				push_text(":c\n\n");
				push_text("dX\n\n\n");
			end
			gen_frames(330);
			while (stream_q.size() != 0 || in_valid || expected_out_q.size() != 0)
				@(negedge clk);
		end
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && expected_out_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
